FILE: rtl/secret_string_masker_top_assert.svh
// ---------------------------------------------------------------------------
// Secret string masker assertion macros
// Property forms used by the masker window RTL.
// ---------------------------------------------------------------------------
`ifndef SECRET_STRING_MASKER_TOP_ASSERT_SVH
`define SECRET_STRING_MASKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SSM_ASSERT_NOW(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (conseq)) \
        else $error("ssm assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SSM_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error("ssm assertion failed");

`endif

FILE: rtl/ssm_pkg.sv
// ---------------------------------------------------------------------------
// Secret string masker package
// Shared constants and control/status types for the masker.
// ---------------------------------------------------------------------------
package ssm_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int FILL_W     = 6;
    localparam int PAT_REGS   = 4;
    localparam int PAT_CHARS  = 32;
    localparam int PAT_IDX_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_TOP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN     = 3'd4;

    localparam logic [BYTE_W-1:0] MASK_CHAR = 8'd42;
    localparam logic [FILL_W-1:0] SINCE_MAX = 6'd63;

    typedef struct packed {
        logic push;
        logic pop;
        logic fin;
    } t_win_ctrl;

    typedef struct packed {
        logic [FILL_W-1:0] pend;
        logic [BYTE_W-1:0] old_byte;
        logic              old_mask;
        logic              old_last;
    } t_win_stat;

endpackage

FILE: rtl/ssm_window.sv
// ---------------------------------------------------------------------------
// Secret string masker window
// Delay line with newest byte at index 0, match compare against the
// aligned pattern, mask flags and emission bookkeeping.
// ---------------------------------------------------------------------------
`include "secret_string_masker_top_assert.svh"

module ssm_window #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  ssm_pkg::t_win_ctrl                       i_ctrl,
    input  logic [ssm_pkg::BYTE_W-1:0]               i_byte,
    input  logic [ssm_pkg::FILL_W-1:0]               i_len,
    input  logic [MAX_PATTERN-1:0][ssm_pkg::BYTE_W-1:0] i_pat_al,
    output ssm_pkg::t_win_stat                       o_stat
);
    import ssm_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] r_buf, n_buf;
    logic [MAX_PATTERN-1:0]             r_flag, n_flag;
    logic [FILL_W-1:0]                  r_fill, n_fill;
    logic [FILL_W-1:0]                  r_since, n_since;
    logic [FILL_W-1:0]                  r_keep, n_keep;
    logic                               r_fin, n_fin;

    logic [FILL_W-1:0]  since_inc;
    logic [FILL_W-1:0]  old_pos;
    logic [MAX_PATTERN-1:0] eq;
    logic               hit;

    always_comb begin
        n_buf  = r_buf;
        n_flag = r_flag;
        if (i_ctrl.push) begin
            n_buf[0]  = i_byte;
            n_flag[0] = 1'b0;
            for (int j = 1; j < MAX_PATTERN; j++) begin
                n_buf[j]  = r_buf[j-1];
                n_flag[j] = r_flag[j-1];
            end
        end

        n_fill = r_fill - FILL_W'(i_ctrl.pop) + FILL_W'(i_ctrl.push);
        since_inc = (r_since == SINCE_MAX) ? SINCE_MAX : r_since + FILL_W'(1);

        for (int j = 0; j < MAX_PATTERN; j++) begin
            eq[j] = (FILL_W'(j) >= i_len) || (n_buf[j] == i_pat_al[j]);
        end
        hit = i_ctrl.push && (i_len != '0) && (n_fill >= i_len) && (since_inc >= i_len)
              && (&eq);

        if (hit) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if (FILL_W'(j) < i_len) begin
                    n_flag[j] = 1'b1;
                end
            end
        end

        n_since = r_since;
        n_keep  = r_keep;
        n_fin   = r_fin;
        if (i_ctrl.push) begin
            n_fin = i_ctrl.fin;
            if (i_ctrl.fin || hit) begin
                n_since = '0;
            end else begin
                n_since = since_inc;
            end
            if (i_ctrl.fin || (i_len == '0)) begin
                n_keep = '0;
            end else if (n_fill < i_len) begin
                n_keep = n_fill;
            end else begin
                n_keep = i_len - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_flag  <= '0;
            r_fill  <= '0;
            r_since <= '0;
            r_keep  <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_flag  <= n_flag;
            r_fill  <= n_fill;
            r_since <= n_since;
            r_keep  <= n_keep;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        old_pos         = r_fill - FILL_W'(1);
        o_stat.pend     = r_fill - r_keep;
        o_stat.old_byte = r_buf[old_pos[IDX_W-1:0]];
        o_stat.old_mask = r_flag[old_pos[IDX_W-1:0]];
        o_stat.old_last = r_fin && (r_fill == FILL_W'(1));
    end

    `SSM_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= FILL_W'(MAX_PATTERN))
    `SSM_ASSERT_NOW(a_pop_has_data, i_ctrl.pop, r_fill > r_keep)
    `SSM_ASSERT_NOW(a_keep_le_fill, 1'b1, r_keep <= r_fill)
    `SSM_ASSERT_NEXT(a_fin_drains_all, i_ctrl.push && i_ctrl.fin, r_keep == '0)

endmodule

FILE: rtl/secret_string_masker_top.sv
// ---------------------------------------------------------------------------
// Secret string masker top level
// Replaces each greedy, non-overlapping occurrence of the configured pattern
// in a byte stream with asterisks. Output trails input by up to the pattern
// length minus one bytes: a byte leaves once no later window can contain it.
// In steady state one byte is accepted and one emitted per cycle; the pattern
// compare is a single parallel window compare. The final byte of a buffer
// drains the delay line at one byte per cycle through the output register,
// so input holds off after a final byte until the delay line has drained.
// The first byte after pattern_length is lowered mid-buffer drains the
// excess held bytes the same way, holding input off until they are gone.
// Output stalls hold input off as well. Input also holds off in the cycle
// after each configuration write while the aligned pattern register reloads.
// ---------------------------------------------------------------------------
module secret_string_masker_top #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ssm_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                              i_is_final,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ssm_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                              o_out_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ssm_pkg::*;

    logic [PAT_REGS-1:0][CFG_DATA_W-1:0] r_pat;
    logic [FILL_W-1:0]                   r_len;
    logic                                r_cfg_busy;
    logic [FILL_W-1:0]                   r_len_eff, n_len_eff;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0]  r_pat_al, n_pat_al;
    logic                                r_out_valid;
    logic [BYTE_W-1:0]                   r_out_byte;
    logic                                r_out_last;

    logic [PAT_CHARS-1:0][BYTE_W-1:0]    pat_chars;
    logic [FILL_W-1:0]                   pos;
    logic                                cfg_wr;
    logic                                out_load;
    t_win_ctrl                           ctrl;
    t_win_stat                           stat;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat      <= '0;
            r_len      <= '0;
            r_cfg_busy <= 1'b0;
        end else begin
            r_cfg_busy <= cfg_wr;
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_PAT_LO:  r_pat[0] <= i_cfg_data;
                    CFG_PAT_MID: r_pat[1] <= i_cfg_data;
                    CFG_PAT_HI:  r_pat[2] <= i_cfg_data;
                    CFG_PAT_TOP: r_pat[3] <= i_cfg_data;
                    CFG_LEN:     r_len    <= i_cfg_data[FILL_W-1:0];
                    default:     r_len    <= r_len;
                endcase
            end
        end
    end

    // align the pattern so that its last character sits at the newest byte
    always_comb begin
        pat_chars = r_pat;
        n_len_eff = (r_len > FILL_W'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN) : r_len;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pos         = n_len_eff - FILL_W'(1) - FILL_W'(j);
            n_pat_al[j] = pat_chars[pos[PAT_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat_al <= n_pat_al;
        if (!i_rst_n) begin
            r_len_eff <= '0;
        end else begin
            r_len_eff <= n_len_eff;
        end
    end

    assign out_load   = !r_out_valid || i_out_ready;
    assign ctrl.pop   = out_load && (stat.pend != '0);
    assign o_in_ready = !r_cfg_busy
                        && ((stat.pend == '0) || ((stat.pend == FILL_W'(1)) && ctrl.pop));
    assign ctrl.push  = i_in_valid && o_in_ready;
    assign ctrl.fin   = i_is_final;

    ssm_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_byte   (i_data_byte),
        .i_len    (r_len_eff),
        .i_pat_al (r_pat_al),
        .o_stat   (stat)
    );

    always_ff @(posedge i_clk) begin
        if (ctrl.pop) begin
            r_out_byte <= stat.old_mask ? MASK_CHAR : stat.old_byte;
            r_out_last <= stat.old_last;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= ctrl.pop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// Secret string masker testbench
// Drives byte buffers through the masker with random bursts on the input
// and random output stalls, and programs patterns of many lengths. A
// scoreboard predicts the masked, delayed byte stream and compares each
// output transaction against it.
// ---------------------------------------------------------------------------
module testbench;
    import ssm_pkg::*;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_masked_item;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_COMB, RX_TRICKLE} t_rx_mode;

    localparam t_cfg_idx CFG_IDX_MAX = '1;
    localparam int RANDOM_ITEMS = 480;
    localparam int SETTLE_CYCLES = 48;
    localparam int DRAIN_LIMIT = 20000;
    localparam int REPORT_LIMIT = 10;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_byte                 i_data_byte;
    logic                  i_is_final;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_byte                 o_out_byte;
    logic                  o_out_last;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    secret_string_masker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_is_final  (i_is_final),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // scoreboard state
    logic [CFG_DATA_W-1:0] pat_word [PAT_REGS];
    logic [FILL_W-1:0]     pat_len;
    t_byte                 held_byte [PAT_CHARS];
    logic                  held_mask [PAT_CHARS];
    int                    held_count;
    int                    since_match;
    t_masked_item          masked_q [$];
    int                    error_count;
    int                    mismatch_count;

    // stimulus state
    t_byte    pat_text [PAT_CHARS];
    logic     small_alpha;
    t_byte    alpha0;
    t_byte    alpha1;
    int       burst_left;
    int       items_sent;
    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;
    int       rx_tick = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_left = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0: rx_mode = RX_FREE;
                1: rx_mode = RX_COIN;
                2: rx_mode = RX_COMB;
                default: rx_mode = RX_TRICKLE;
            endcase
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_FREE: i_out_ready = 1'b1;
            RX_COIN: i_out_ready = ($urandom_range(0, 1) == 1);
            RX_COMB: i_out_ready = ((rx_tick % 3) != 0);
            default: i_out_ready = ($urandom_range(0, 5) == 0);
        endcase
    end

    function automatic t_byte pattern_char(input int k);
        return pat_word[k / 8][(k % 8) * 8 +: 8];
    endfunction

    task automatic apply_reg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_PAT_LO:  pat_word[0] = value;
            CFG_PAT_MID: pat_word[1] = value;
            CFG_PAT_HI:  pat_word[2] = value;
            CFG_PAT_TOP: pat_word[3] = value;
            CFG_LEN:     pat_len = value[FILL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic shift_out_oldest(input logic last);
        t_masked_item item;
        int k;
        item.data = held_mask[0] ? MASK_CHAR : held_byte[0];
        item.last = last;
        masked_q.push_back(item);
        for (k = 0; k + 1 < held_count; k++) begin
            held_byte[k] = held_byte[k + 1];
            held_mask[k] = held_mask[k + 1];
        end
        held_count--;
        held_mask[held_count] = 1'b0;
    endtask

    task automatic predict_masking(input t_byte b, input logic fin);
        int eff;
        int base;
        int k;
        logic hit;
        eff = (pat_len > PAT_CHARS) ? PAT_CHARS : int'(pat_len);
        if (held_count >= PAT_CHARS) held_count = PAT_CHARS - 1;
        held_byte[held_count] = b;
        held_mask[held_count] = 1'b0;
        held_count++;
        if (since_match < SINCE_MAX) since_match++;
        if (eff > 0 && held_count >= eff && since_match >= eff) begin
            base = held_count - eff;
            hit = 1'b1;
            for (k = 0; k < eff; k++) begin
                if (held_byte[base + k] != pattern_char(k)) hit = 1'b0;
            end
            if (hit) begin
                for (k = 0; k < eff; k++) held_mask[base + k] = 1'b1;
                since_match = 0;
            end
        end
        if (fin) begin
            while (held_count > 0) shift_out_oldest(held_count == 1);
            for (k = 0; k < PAT_CHARS; k++) held_mask[k] = 1'b0;
            since_match = 0;
        end else begin
            while (held_count > 0 && held_count >= eff) shift_out_oldest(1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        t_masked_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) apply_reg_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) predict_masking(i_data_byte, i_is_final);
            if (o_out_valid && i_out_ready) begin
                if (masked_q.size() == 0) begin
                    error_count++;
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected output: byte=%h last=%b", o_out_byte, o_out_last);
                    mismatch_count++;
                end else begin
                    want = masked_q.pop_front();
                    if (o_out_byte !== want.data || o_out_last !== want.last) begin
                        error_count++;
                        if (mismatch_count < REPORT_LIMIT)
                            $display("mismatch: byte exp=%h act=%h, last exp=%b act=%b",
                                     want.data, o_out_byte, want.last, o_out_last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    function automatic t_byte text_byte();
        logic [31:0] r;
        r = $urandom;
        if (small_alpha) return r[0] ? alpha1 : alpha0;
        return r[7:0];
    endfunction

    task automatic push_byte(input t_byte b, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_data_byte = b;
        i_is_final = fin;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle_output();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (masked_q.size() > 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_pattern_regs();
        logic [CFG_DATA_W-1:0] word;
        int r;
        int c;
        for (r = 0; r < PAT_REGS; r++) begin
            for (c = 0; c < 8; c++) word[c * 8 +: 8] = pat_text[r * 8 + c];
            write_reg(CFG_PAT_LO + r[CFG_IDX_W-1:0], word);
        end
    endtask

    task automatic fill_pattern(input t_byte value);
        int i;
        for (i = 0; i < PAT_CHARS; i++) pat_text[i] = value;
    endtask

    task automatic send_text(input int eff, input logic closed);
        t_byte text_q [$];
        int kind;
        int keep;
        int cut;
        int j;
        logic [31:0] r;
        repeat ($urandom_range(1, 5)) begin
            kind = $urandom_range(0, 9);
            if (eff > 0 && kind < 5) begin
                for (j = 0; j < eff; j++) text_q.push_back(pat_text[j]);
            end else if (eff > 0 && kind < 7) begin
                keep = $urandom_range(1, eff);
                for (j = 0; j < keep; j++) text_q.push_back(pat_text[j]);
                if (keep == eff) begin
                    cut = text_q.size() - 1 - $urandom_range(0, eff - 1);
                    r = $urandom_range(1, 255);
                    text_q[cut] = text_q[cut] ^ r[7:0];
                end
            end else begin
                repeat ($urandom_range(1, 6)) text_q.push_back(text_byte());
            end
        end
        for (j = 0; j < text_q.size(); j++)
            push_byte(text_q[j], closed && (j == text_q.size() - 1));
    endtask

    task automatic test_passthrough();
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        settle_output();
    endtask

    task automatic test_overlap_rejection();
        fill_pattern(8'h00);
        pat_text[0] = "a";
        pat_text[1] = "a";
        write_pattern_regs();
        write_reg(CFG_LEN, 64'd2);
        push_byte("a", 1'b0);
        push_byte("a", 1'b0);
        push_byte("a", 1'b0);
        push_byte("x", 1'b1);
        settle_output();
    endtask

    task automatic test_short_buffer();
        push_byte("a", 1'b1);
        settle_output();
    endtask

    task automatic test_length_change();
        fill_pattern(8'h00);
        pat_text[0] = "a";
        pat_text[1] = "b";
        pat_text[2] = "c";
        pat_text[3] = "d";
        write_pattern_regs();
        write_reg(CFG_LEN, 64'd4);
        push_byte("x", 1'b0);
        push_byte("a", 1'b0);
        settle_output();
        write_reg(CFG_LEN, 64'd2);
        push_byte("b", 1'b0);
        push_byte("z", 1'b1);
        settle_output();
    endtask

    task automatic test_long_length();
        int i;
        for (i = 0; i < PAT_CHARS; i++) pat_text[i] = text_byte();
        write_pattern_regs();
        write_reg(CFG_LEN, '1);
        push_byte(pat_text[0], 1'b0);
        push_byte(pat_text[1], 1'b0);
        push_byte(8'hFF, 1'b1);
        settle_output();
    endtask

    task automatic test_bad_index();
        fill_pattern(8'h00);
        write_pattern_regs();
        write_reg(CFG_LEN, 64'd1);
        write_reg(CFG_LEN + 3'd1, {$urandom, $urandom});
        write_reg(CFG_IDX_MAX, '1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        settle_output();
    endtask

    task automatic test_random_streams();
        int start;
        int pick;
        int len;
        int eff;
        int nbuf;
        int i;
        logic [CFG_DATA_W-1:0] len_word;
        logic [31:0] r;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            settle_output();
            pick = $urandom_range(0, 99);
            if (pick < 5) len = 0;
            else if (pick < 60) len = $urandom_range(1, 4);
            else if (pick < 85) len = $urandom_range(5, 16);
            else if (pick < 95) len = $urandom_range(17, 32);
            else len = $urandom_range(33, 63);
            eff = (len > PAT_CHARS) ? PAT_CHARS : len;
            small_alpha = ($urandom_range(0, 1) == 1);
            r = $urandom;
            alpha0 = r[7:0];
            r = $urandom_range(1, 255);
            alpha1 = alpha0 ^ r[7:0];
            for (i = 0; i < PAT_CHARS; i++) pat_text[i] = text_byte();
            write_pattern_regs();
            if ($urandom_range(0, 4) == 0)
                write_reg(t_cfg_idx'($urandom_range(CFG_LEN + 1, CFG_IDX_MAX)),
                          {$urandom, $urandom});
            len_word = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 1) len_word = '0;
            len_word[FILL_W-1:0] = len[FILL_W-1:0];
            write_reg(CFG_LEN, len_word);
            nbuf = $urandom_range(1, 4);
            for (i = 0; i < nbuf; i++)
                send_text(eff, (i < nbuf - 1) || ($urandom_range(0, 2) != 0));
        end
        push_byte(text_byte(), 1'b1);
    endtask

    initial begin
        int waited;
        int i;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_is_final = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PAT_LO;
        i_cfg_data = '0;
        for (i = 0; i < PAT_REGS; i++) pat_word[i] = '0;
        for (i = 0; i < PAT_CHARS; i++) begin
            held_byte[i] = '0;
            held_mask[i] = 1'b0;
            pat_text[i] = '0;
        end
        pat_len = '0;
        held_count = 0;
        since_match = 0;
        error_count = 0;
        mismatch_count = 0;
        small_alpha = 1'b0;
        alpha0 = "a";
        alpha1 = "b";
        burst_left = 0;
        items_sent = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_passthrough();
        test_overlap_rejection();
        test_short_buffer();
        test_length_change();
        test_long_length();
        test_bad_index();
        test_random_streams();

        i_in_valid = 1'b0;
        waited = 0;
        while (masked_q.size() > 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        error_count += masked_q.size();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
